/* design/rdc_pkg.sv */
// shared types and constants for the ray to disk cap intersection core
`timescale 1ns / 1ps
`default_nettype none
package rdc_pkg;

  localparam int FRAC_BITS        = 16;
  localparam int PARALLEL_EPSILON = 66;
  localparam int EPS_SQ           = PARALLEL_EPSILON * PARALLEL_EPSILON;
  localparam int EPS_W            = $clog2(EPS_SQ + 1);
  localparam int CFG_IDX_W        = 4;
  localparam int MAG_W            = 64;
  localparam int KP_W             = MAG_W + EPS_W;
  localparam int MSQ_H            = (KP_W + 3) / 4;
  localparam int NB_W             = 67 + FRAC_BITS;
  localparam int NUM_W            = 97;
  localparam int REM_W            = NUM_W - 1;
  localparam int QUO_W            = 31;
  localparam int AAH_W            = 95;
  localparam int EW               = 66;
  localparam int DIST_W           = 31;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X     = 4'd0,
    REG_CENTER_Y     = 4'd1,
    REG_CENTER_Z     = 4'd2,
    REG_AXIS_X       = 4'd3,
    REG_AXIS_Y       = 4'd4,
    REG_AXIS_Z       = 4'd5,
    REG_CAP_DIAMETER = 4'd6,
    REG_CAP_HEIGHT   = 4'd7
  } cfg_reg_e;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [32:0] com_t;
  typedef logic signed [63:0] ah_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    coord_t origin_z;
    coord_t direction_x;
    coord_t direction_y;
    coord_t direction_z;
  } ray_in_t;

  typedef struct packed {
    logic              hit;
    logic              which_cap;
    logic [DIST_W-1:0] distance;
  } hit_out_t;

  typedef struct packed {
    coord_t [2:0]     center;
    coord_t [2:0]     axis;
    ah_t [2:0]        axh;
    logic [AAH_W-1:0] aah;
    logic [KP_W-1:0]  kpar;
    logic [61:0]      dsq;
  } geom_t;

  typedef struct packed {
    coord_t [2:0] dir;
    com_t [2:0]   com;
    logic         ok_b;
    logic         ok_t;
    logic         sat_b;
    logic         sat_t;
  } side_t;

endpackage
`default_nettype wire

/* design/rdc_cfg.sv */
// configuration registers and values derived from them
`timescale 1ns / 1ps
`default_nettype none
module rdc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [31:0]                    cfg_data,
  output rdc_pkg::geom_t                      geom
);

  localparam logic [rdc_pkg::EPS_W-1:0] EPS_V = rdc_pkg::EPS_W'(rdc_pkg::EPS_SQ);

  rdc_pkg::coord_t [2:0] center_r;
  rdc_pkg::coord_t [2:0] axis_r;
  logic [30:0]           diam_r;
  logic [30:0]           height_r;

  rdc_pkg::ah_t [2:0]    ah_r;
  logic [63:0]           sq_r [3];
  logic [61:0]           dsq_r;
  logic [63:0]           aa_r;
  logic [62:0]           aahl_r;
  logic [62:0]           aahh_r;
  logic [31+rdc_pkg::EPS_W:0] kl_r;
  logic [31+rdc_pkg::EPS_W:0] kh_r;
  logic [rdc_pkg::AAH_W-1:0]  aah_r;
  logic [rdc_pkg::KP_W-1:0]   kpar_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      axis_r   <= {32'sd65536, 32'sd0, 32'sd0};
      diam_r   <= 31'd65536;
      height_r <= 31'd65536;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rdc_pkg::REG_CENTER_X:     center_r[0] <= cfg_data;
        rdc_pkg::REG_CENTER_Y:     center_r[1] <= cfg_data;
        rdc_pkg::REG_CENTER_Z:     center_r[2] <= cfg_data;
        rdc_pkg::REG_AXIS_X:       axis_r[0]   <= cfg_data;
        rdc_pkg::REG_AXIS_Y:       axis_r[1]   <= cfg_data;
        rdc_pkg::REG_AXIS_Z:       axis_r[2]   <= cfg_data;
        rdc_pkg::REG_CAP_DIAMETER: diam_r      <= cfg_data[30:0];
        rdc_pkg::REG_CAP_HEIGHT:   height_r    <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // derived values, registered in order: per-axis products, squared axis length, partial products, sums
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ah_r[i] <= axis_r[i] * $signed({1'b0, height_r});
      sq_r[i] <= 64'(axis_r[i] * axis_r[i]);
    end
    dsq_r  <= diam_r * diam_r;
    aa_r   <= sq_r[0] + sq_r[1] + sq_r[2];
    aahl_r <= aa_r[31:0] * height_r;
    aahh_r <= aa_r[63:32] * height_r;
    kl_r   <= aa_r[31:0] * EPS_V;
    kh_r   <= aa_r[63:32] * EPS_V;
    aah_r  <= (rdc_pkg::AAH_W'(aahh_r) << 32) + rdc_pkg::AAH_W'(aahl_r);
    kpar_r <= (rdc_pkg::KP_W'(kh_r) << 32) + rdc_pkg::KP_W'(kl_r);
  end

  assign geom.center = center_r;
  assign geom.axis   = axis_r;
  assign geom.axh    = ah_r;
  assign geom.aah    = aah_r;
  assign geom.kpar   = kpar_r;
  assign geom.dsq    = dsq_r;

endmodule
`default_nettype wire

/* design/rdc_front.sv */
// front pipeline: dot products, parallel test, numerators and saturation check
`timescale 1ns / 1ps
`default_nettype none
module rdc_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  rdc_pkg::ray_in_t                 in_data,
  input  rdc_pkg::geom_t                   geom,
  output logic                             v_o,
  output logic [rdc_pkg::REM_W-1:0]        nabs_b,
  output logic [rdc_pkg::REM_W-1:0]        nabs_t,
  output logic [rdc_pkg::MAG_W-1:0]        mag,
  output rdc_pkg::side_t                   side
);

  localparam int H = rdc_pkg::MSQ_H;

  logic [7:1]              v_r;
  rdc_pkg::side_t          cr_r [1:6];
  rdc_pkg::coord_t [2:0]   org;
  rdc_pkg::coord_t [2:0]   dir;
  rdc_pkg::side_t          s1_nxt;

  logic signed [63:0]      pad2_r [3];
  logic signed [64:0]      pca2_r [3];
  logic signed [65:0]      ad3_r;
  logic signed [66:0]      nb3_r;
  logic signed [65:0]      adabs;
  logic [rdc_pkg::MAG_W-1:0] mag4_r, mag5_r, mag6_r;
  logic                    adneg4_r, adneg5_r;
  logic                    magz4_r, magz5_r, magz6_r;
  logic signed [rdc_pkg::NB_W-1:0]  nb4_r;
  logic [2*H-1:0]          hh5_r, hl5_r, ll5_r;
  logic                    mbig5_r;
  logic signed [rdc_pkg::NUM_W-1:0] nb5_r, nt5_r, nbabs, ntabs;
  logic [4*H-1:0]          msq;
  logic                    par6_r, negb6_r, negt6_r;
  logic [rdc_pkg::REM_W-1:0] nb6_r, nt6_r, nb7_r, nt7_r;
  logic [rdc_pkg::MAG_W-1:0] mag7_r;
  rdc_pkg::side_t          s7_nxt;
  rdc_pkg::side_t          s7_r;

  assign org = {in_data.origin_z, in_data.origin_y, in_data.origin_x};
  assign dir = {in_data.direction_z, in_data.direction_y, in_data.direction_x};

  always_comb begin
    s1_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.dir[i] = dir[i];
      s1_nxt.com[i] = $signed({geom.center[i][31], geom.center[i]})
                    - $signed({org[i][31], org[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r[1] <= s1_nxt;
      for (int k = 2; k <= 6; k++) begin
        cr_r[k] <= cr_r[k-1];
      end
    end
  end

  // stage 2: products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pad2_r[i] <= cr_r[1].dir[i] * geom.axis[i];
        pca2_r[i] <= cr_r[1].com[i] * geom.axis[i];
      end
    end
  end

  // stage 3: sums
  always_ff @(posedge clk) begin
    if (en) begin
      ad3_r <= pad2_r[0] + pad2_r[1] + pad2_r[2];
      nb3_r <= pca2_r[0] + pca2_r[1] + pca2_r[2];
    end
  end

  // stage 4: magnitude of the axis dot direction
  assign adabs = ad3_r[65] ? -ad3_r : ad3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      mag4_r   <= adabs[rdc_pkg::MAG_W-1:0];
      adneg4_r <= ad3_r[65];
      magz4_r  <= (ad3_r == '0);
      nb4_r    <= rdc_pkg::NB_W'(nb3_r) <<< rdc_pkg::FRAC_BITS;
    end
  end

  // stage 5: partial squares, top cap numerator
  always_ff @(posedge clk) begin
    if (en) begin
      hh5_r    <= mag4_r[2*H-1:H] * mag4_r[2*H-1:H];
      hl5_r    <= mag4_r[2*H-1:H] * mag4_r[H-1:0];
      ll5_r    <= mag4_r[H-1:0] * mag4_r[H-1:0];
      mbig5_r  <= |mag4_r[rdc_pkg::MAG_W-1:2*H];
      nb5_r    <= rdc_pkg::NUM_W'(nb4_r);
      nt5_r    <= rdc_pkg::NUM_W'(nb4_r) + $signed({2'b00, geom.aah});
      mag5_r   <= mag4_r;
      adneg5_r <= adneg4_r;
      magz5_r  <= magz4_r;
    end
  end

  // stage 6: parallel test, sign test, absolute numerators
  assign msq = ((4*H)'(hh5_r) << (2*H)) + ((4*H)'(hl5_r) << (H+1)) + (4*H)'(ll5_r);
  assign nbabs = nb5_r[rdc_pkg::NUM_W-1] ? -nb5_r : nb5_r;
  assign ntabs = nt5_r[rdc_pkg::NUM_W-1] ? -nt5_r : nt5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      par6_r  <= !mbig5_r && (msq < (4*H)'(geom.kpar));
      negb6_r <= (nb5_r != '0) && (nb5_r[rdc_pkg::NUM_W-1] != adneg5_r);
      negt6_r <= (nt5_r != '0) && (nt5_r[rdc_pkg::NUM_W-1] != adneg5_r);
      nb6_r   <= nbabs[rdc_pkg::REM_W-1:0];
      nt6_r   <= ntabs[rdc_pkg::REM_W-1:0];
      mag6_r  <= mag5_r;
      magz6_r <= magz5_r;
    end
  end

  // stage 7: cap qualification and quotient overflow
  always_comb begin
    s7_nxt       = cr_r[6];
    s7_nxt.ok_b  = !magz6_r && !par6_r && !negb6_r;
    s7_nxt.ok_t  = !magz6_r && !par6_r && !negt6_r;
    s7_nxt.sat_b = nb6_r >= (rdc_pkg::REM_W'(mag6_r) << rdc_pkg::QUO_W);
    s7_nxt.sat_t = nt6_r >= (rdc_pkg::REM_W'(mag6_r) << rdc_pkg::QUO_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_r   <= s7_nxt;
      nb7_r  <= nb6_r;
      nt7_r  <= nt6_r;
      mag7_r <= mag6_r;
    end
  end

  assign v_o    = v_r[7];
  assign nabs_b = nb7_r;
  assign nabs_t = nt7_r;
  assign mag    = mag7_r;
  assign side   = s7_r;

endmodule
`default_nettype wire

/* design/rdc_div.sv */
// pipelined restoring divider, one quotient bit per stage for both caps
`timescale 1ns / 1ps
`default_nettype none
module rdc_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_i,
  input  wire logic [rdc_pkg::REM_W-1:0]   nabs_b,
  input  wire logic [rdc_pkg::REM_W-1:0]   nabs_t,
  input  wire logic [rdc_pkg::MAG_W-1:0]   mag,
  input  rdc_pkg::side_t                   side_i,
  output logic                             v_o,
  output logic [rdc_pkg::QUO_W-1:0]        q_b,
  output logic [rdc_pkg::QUO_W-1:0]        q_t,
  output rdc_pkg::side_t                   side_o
);

  localparam int N = rdc_pkg::QUO_W;

  logic                        v_r   [N];
  logic [rdc_pkg::REM_W-1:0]   rb_r  [N-1];
  logic [rdc_pkg::REM_W-1:0]   rt_r  [N-1];
  logic [N-1:0]                qb_r  [N];
  logic [N-1:0]                qt_r  [N];
  logic [rdc_pkg::MAG_W-1:0]   mag_r [N-1];
  rdc_pkg::side_t              sd_r  [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                      v_in;
    logic [rdc_pkg::REM_W-1:0] rb_in, rt_in, sh;
    logic [N-1:0]              qb_in, qt_in;
    logic [rdc_pkg::MAG_W-1:0] m_in;
    rdc_pkg::side_t            s_in;
    logic                      geb, get;

    if (k == 0) begin : g_first
      assign v_in  = v_i;
      assign rb_in = nabs_b;
      assign rt_in = nabs_t;
      assign qb_in = '0;
      assign qt_in = '0;
      assign m_in  = mag;
      assign s_in  = side_i;
    end else begin : g_next
      assign v_in  = v_r[k-1];
      assign rb_in = rb_r[k-1];
      assign rt_in = rt_r[k-1];
      assign qb_in = qb_r[k-1];
      assign qt_in = qt_r[k-1];
      assign m_in  = mag_r[k-1];
      assign s_in  = sd_r[k-1];
    end

    assign sh  = rdc_pkg::REM_W'(m_in) << (N-1-k);
    assign geb = rb_in >= sh;
    assign get = rt_in >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qb_r[k] <= qb_in | (N'(geb) << (N-1-k));
        qt_r[k] <= qt_in | (N'(get) << (N-1-k));
        sd_r[k] <= s_in;
      end
    end

    if (k < N-1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rb_r[k]  <= geb ? rb_in - sh : rb_in;
          rt_r[k]  <= get ? rt_in - sh : rt_in;
          mag_r[k] <= m_in;
        end
      end
    end
  end

  assign v_o    = v_r[N-1];
  assign side_o = sd_r[N-1];
  assign q_b    = sd_r[N-1].sat_b ? '1 : qb_r[N-1];
  assign q_t    = sd_r[N-1].sat_t ? '1 : qt_r[N-1];

endmodule
`default_nettype wire

/* design/rdc_back.sv */
// back pipeline: hit point, radius test and cap selection
`timescale 1ns / 1ps
`default_nettype none
module rdc_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        v_i,
  input  wire logic [rdc_pkg::QUO_W-1:0]   q_b,
  input  wire logic [rdc_pkg::QUO_W-1:0]   q_t,
  input  rdc_pkg::side_t                   side_i,
  input  rdc_pkg::geom_t                   geom,
  output logic                             v_o,
  output rdc_pkg::hit_out_t                res
);

  localparam int EW = rdc_pkg::EW;

  logic [5:1]              v_r;
  logic [rdc_pkg::QUO_W-1:0] qb_r [1:4];
  logic [rdc_pkg::QUO_W-1:0] qt_r [1:4];
  logic                    okb_r [1:4];
  logic                    okt_r [1:4];
  rdc_pkg::com_t [2:0]     com1_r;
  logic signed [63:0]      pdb1_r [3];
  logic signed [63:0]      pdt1_r [3];
  logic signed [EW-1:0]    eb2_r [3];
  logic signed [EW-1:0]    et2_r [3];
  logic signed [EW-1:0]    shb [3];
  logic signed [EW-1:0]    sht [3];
  logic signed [EW-1:0]    ab [3];
  logic signed [EW-1:0]    at [3];
  logic [30:0]             vb3_r [3];
  logic [30:0]             vt3_r [3];
  logic                    bigb3_r, bigt3_r, bigb4_r, bigt4_r;
  logic [61:0]             sqb4_r [3];
  logic [61:0]             sqt4_r [3];
  logic [63:0]             sumb, sumt;
  logic                    hitb, hitt;
  rdc_pkg::hit_out_t       res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[4:1], v_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qb_r[1]  <= q_b;
      qt_r[1]  <= q_t;
      okb_r[1] <= side_i.ok_b;
      okt_r[1] <= side_i.ok_t;
      for (int k = 2; k <= 4; k++) begin
        qb_r[k]  <= qb_r[k-1];
        qt_r[k]  <= qt_r[k-1];
        okb_r[k] <= okb_r[k-1];
        okt_r[k] <= okt_r[k-1];
      end
    end
  end

  // stage 1: direction times distance
  always_ff @(posedge clk) begin
    if (en) begin
      com1_r <= side_i.com;
      for (int i = 0; i < 3; i++) begin
        pdb1_r[i] <= side_i.dir[i] * $signed({1'b0, q_b});
        pdt1_r[i] <= side_i.dir[i] * $signed({1'b0, q_t});
      end
    end
  end

  // stage 2: offset of the hit point from each cap center
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        eb2_r[i] <= EW'(pdb1_r[i]) - (EW'(com1_r[i]) <<< rdc_pkg::FRAC_BITS);
        et2_r[i] <= EW'(pdt1_r[i]) - (EW'(com1_r[i]) <<< rdc_pkg::FRAC_BITS)
                  - EW'(geom.axh[i]);
      end
    end
  end

  // stage 3: floor to format, magnitude, range check
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shb[i] = eb2_r[i] >>> rdc_pkg::FRAC_BITS;
      sht[i] = et2_r[i] >>> rdc_pkg::FRAC_BITS;
      ab[i]  = shb[i][EW-1] ? -shb[i] : shb[i];
      at[i]  = sht[i][EW-1] ? -sht[i] : sht[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        vb3_r[i] <= ab[i][30:0];
        vt3_r[i] <= at[i][30:0];
      end
      bigb3_r <= (|ab[0][EW-1:31]) | (|ab[1][EW-1:31]) | (|ab[2][EW-1:31]);
      bigt3_r <= (|at[0][EW-1:31]) | (|at[1][EW-1:31]) | (|at[2][EW-1:31]);
    end
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqb4_r[i] <= vb3_r[i] * vb3_r[i];
        sqt4_r[i] <= vt3_r[i] * vt3_r[i];
      end
      bigb4_r <= bigb3_r;
      bigt4_r <= bigt3_r;
    end
  end

  // stage 5: radius test and cap priority
  assign sumb = 64'(sqb4_r[0]) + 64'(sqb4_r[1]) + 64'(sqb4_r[2]);
  assign sumt = 64'(sqt4_r[0]) + 64'(sqt4_r[1]) + 64'(sqt4_r[2]);
  assign hitb = okb_r[4] && !bigb4_r && ({sumb, 2'b00} <= 66'(geom.dsq));
  assign hitt = okt_r[4] && !bigt4_r && ({sumt, 2'b00} <= 66'(geom.dsq));

  always_ff @(posedge clk) begin
    if (en) begin
      if (hitb) begin
        res_r.hit       <= 1'b1;
        res_r.which_cap <= 1'b0;
        res_r.distance  <= qb_r[4];
      end else if (hitt) begin
        res_r.hit       <= 1'b1;
        res_r.which_cap <= 1'b1;
        res_r.distance  <= qt_r[4];
      end else begin
        res_r <= '0;
      end
    end
  end

  assign v_o = v_r[5];
  assign res = res_r;

endmodule
`default_nettype wire

/* design/ray_disk_cap_intersect_core.sv */
// top level of the ray to cylinder end cap intersection core
// usage:
//   in_valid/in_stall/in_data carry one ray per transaction (origin and
//   direction, Q16.16); out_valid/out_stall/out_data return one result per
//   ray: hit flag, which cap (base first, then top), distance t in Q15.16.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the eight geometry
//   registers; cfg_ready is always high, indexes above seven are dropped.
//   write the geometry only while no ray is in flight.
// pipeline: 7 front stages, 31 divider stages (one quotient bit each) and
//   5 back stages; the 31-stage divider sets the depth.
// throughput: one ray per cycle while the pipeline is not stalled.
// reset: synchronous active-low rst_n clears all pipeline valid bits and
//   loads the geometry reset values (axis 0,0,1; diameter and height 1).
// stall: while out_valid is high and out_stall is high the whole pipeline
//   holds and in_stall is raised; nothing is dropped or repeated.
`timescale 1ns / 1ps
`default_nettype none
module ray_disk_cap_intersect_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  rdc_pkg::ray_in_t                   in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output rdc_pkg::hit_out_t                  out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [rdc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  logic                            en;
  rdc_pkg::geom_t                  geom;
  logic                            fv;
  logic [rdc_pkg::REM_W-1:0]       nabs_b, nabs_t;
  logic [rdc_pkg::MAG_W-1:0]       mag;
  rdc_pkg::side_t                  fside, dside;
  logic                            dv;
  logic [rdc_pkg::QUO_W-1:0]       q_b, q_t;

  assign en        = !(out_valid && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  rdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .geom      (geom)
  );

  rdc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .geom     (geom),
    .v_o      (fv),
    .nabs_b   (nabs_b),
    .nabs_t   (nabs_t),
    .mag      (mag),
    .side     (fside)
  );

  rdc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (fv),
    .nabs_b (nabs_b),
    .nabs_t (nabs_t),
    .mag    (mag),
    .side_i (fside),
    .v_o    (dv),
    .q_b    (q_b),
    .q_t    (q_t),
    .side_o (dside)
  );

  rdc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (dv),
    .q_b    (q_b),
    .q_t    (q_t),
    .side_i (dside),
    .geom   (geom),
    .v_o    (out_valid),
    .res    (out_data)
  );

`ifndef SYNTHESIS
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> !out_data.which_cap && out_data.distance == '0)
    else $error("miss result carries cap or distance");

  a_stall_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result lost while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire
